// ----- hdl/sha1sh_pkg.sv -----
package sha1sh_pkg;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	// request from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic has_byte;
		logic is_last;
	} req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0] word_index;
		logic last_word;
	} res_t;

endpackage

// ----- hdl/sha1sh_front.sv -----
module sha1sh_front #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sha1sh_pkg::req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output sha1sh_pkg::req_t out_req
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sha1sh_pkg::req_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop, drop;

	// items with no byte and no end are dropped here
	assign drop = in_valid && !in_req.has_byte && !in_req.is_last;
	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign push = in_valid && in_ready && !drop;
	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && out_ready;
	assign out_req = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// ----- hdl/sha1sh_back.sv -----
module sha1sh_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sha1sh_pkg::req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output sha1sh_pkg::res_t out_res
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PAD  = 6'b000010,
		S_LOAD = 6'b000100,
		S_RND  = 6'b001000,
		S_ADD  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t st_q;
	// block buffer as 16 big-endian words, byte lanes written one at a time
	logic [31:0] buf_q [16];
	logic [5:0] fill_q;
	logic [31:0] blocks_q;
	logic [31:0] h_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0] rnd_q;
	logic [5:0] pidx_q;
	logic fin_q, two_q, pad_q;
	logic [2:0] oidx_q;
	logic [63:0] bits;
	logic [31:0] wn, f, k, t;

	assign bits = {23'd0, blocks_q, 9'd0} + {55'd0, fill_q, 3'd0};
	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign out_res.digest_word = h_q[oidx_q];
	assign out_res.word_index = oidx_q;
	assign out_res.last_word = (oidx_q == 3'd4);

	always_comb begin
		logic [31:0] x;
		x = w_q[0] ^ w_q[2] ^ w_q[8] ^ w_q[13];
		wn = (rnd_q < 7'd16) ? w_q[0] : {x[30:0], x[31]};
		if (rnd_q < 7'd20) begin
			f = d_q ^ (b_q & (c_q ^ d_q));
			k = sha1sh_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1sh_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (d_q & (b_q | c_q));
			k = sha1sh_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1sh_pkg::K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wn;
	end

	// padding bytes written one per cycle; in the last padded block, byte 56..63 hold the length
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (in_valid && in_req.has_byte)
				buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= in_req.data_byte;
			S_PAD: begin
				if (pidx_q == fill_q && !fin_q)
					buf_q[pidx_q[5:2]][{~pidx_q[1:0], 3'b000} +: 8] <= sha1sh_pkg::PAD_BYTE;
				else if (pidx_q >= sha1sh_pkg::LEN_POS && !two_q)
					buf_q[pidx_q[5:2]][{~pidx_q[1:0], 3'b000} +: 8] <=
						bits[{~pidx_q[2:0], 3'b111} -: 8];
				else buf_q[pidx_q[5:2]][{~pidx_q[1:0], 3'b000} +: 8] <= 8'd0;
			end
			default: ;
		endcase
		case (st_q)
			S_LOAD: begin
				for (int i = 0; i < 16; i++)
					w_q[i] <= buf_q[i];
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
			end
			S_RND: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wn;
				a_q <= t; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]}; d_q <= c_q; e_q <= d_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			fill_q <= '0;
			blocks_q <= '0;
			h_q[0] <= sha1sh_pkg::H0; h_q[1] <= sha1sh_pkg::H1; h_q[2] <= sha1sh_pkg::H2;
			h_q[3] <= sha1sh_pkg::H3; h_q[4] <= sha1sh_pkg::H4;
			rnd_q <= '0; pidx_q <= '0; fin_q <= 1'b0; two_q <= 1'b0; pad_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (in_valid) begin
					if (in_req.has_byte) begin
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							fin_q <= in_req.is_last;
							two_q <= 1'b0;
							st_q <= S_LOAD;
						end else if (in_req.is_last) begin
							pidx_q <= fill_q + 6'd1;
							two_q <= (fill_q + 6'd1 >= sha1sh_pkg::LEN_POS);
							pad_q <= 1'b1;
							st_q <= S_PAD;
						end
					end else if (in_req.is_last) begin
						pidx_q <= fill_q;
						two_q <= (fill_q >= sha1sh_pkg::LEN_POS);
						pad_q <= 1'b1;
						st_q <= S_PAD;
					end
				end
				S_PAD: begin
					pidx_q <= pidx_q + 6'd1;
					if (pidx_q == 6'd63) st_q <= S_LOAD;
				end
				S_LOAD: begin rnd_q <= '0; st_q <= S_RND; end
				S_RND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) st_q <= S_ADD;
				end
				S_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
					oidx_q <= '0;
					if (!pad_q) begin
						blocks_q <= blocks_q + 32'd1;
						if (fin_q) begin
							// full block ended message: pad a fresh block
							fin_q <= 1'b0;
							pidx_q <= 6'd0;
							two_q <= 1'b0;
							pad_q <= 1'b1;
							st_q <= S_PAD;
						end else begin
							st_q <= S_IDLE;
						end
					end else if (two_q) begin
						two_q <= 1'b0;
						fin_q <= 1'b1;
						pidx_q <= 6'd0;
						st_q <= S_PAD;
					end else begin
						st_q <= S_OUT;
					end
				end
				S_OUT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd4) begin
						st_q <= S_IDLE;
						fill_q <= '0;
						blocks_q <= '0;
						fin_q <= 1'b0;
						pad_q <= 1'b0;
						h_q[0] <= sha1sh_pkg::H0; h_q[1] <= sha1sh_pkg::H1;
						h_q[2] <= sha1sh_pkg::H2; h_q[3] <= sha1sh_pkg::H3;
						h_q[4] <= sha1sh_pkg::H4;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/sha1_stream_hasher_core.sv -----
// SHA-1 hasher, one message byte per request; the back end takes a byte only
// while idle. A block is compressed one round per cycle (load, the rounds, then
// add); a message end sweeps the block buffer from the pad position to byte 63
// before each padded block, then emits five digest words (h0 first). A
// QDEPTH-deep queue decouples the input from the back end.
module sha1_stream_hasher_core #(
	parameter int QDEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata, // data_byte
	input  logic s_tuser,       // has_byte
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata, // digest_word, word_index, 5'b0
	output logic m_tlast
);
	sha1sh_pkg::req_t in_req, q_req;
	sha1sh_pkg::res_t res;
	logic q_valid, q_ready;

	assign in_req.data_byte = s_tdata;
	assign in_req.has_byte = s_tuser;
	assign in_req.is_last = s_tlast;

	sha1sh_front #(.DEPTH(QDEPTH)) u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_req,
		.out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
	);

	sha1sh_back u_back (
		.clk, .arst_n, .in_valid(q_valid), .in_ready(q_ready), .in_req(q_req),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
	);

	assign m_tdata = {5'd0, res.word_index, res.digest_word};
	assign m_tlast = res.last_word;
endmodule

// ----- sim/sha1_stream_hasher_checker.sv -----
module sha1_stream_hasher_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [7:0] s_tdata,
	input  logic s_tuser,
	input  logic s_tlast,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [39:0] m_tdata,
	input  logic m_tlast,
	output int errors,
	output int pending
);
	logic [31:0] chain[5];
	logic [7:0] buffer[64];
	int unsigned fill;
	logic [31:0] blocks;
	sha1sh_pkg::res_t digest_q[$];

	function automatic logic [31:0] rotl(logic [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic compress();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		for (int i = 0; i < 16; i++)
			w[i] = {buffer[4*i], buffer[4*i+1], buffer[4*i+2], buffer[4*i+3]};
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 16) begin
				x = w[i];
			end else begin
				x = rotl(w[i%16] ^ w[(i-14)%16] ^ w[(i-8)%16] ^ w[(i-3)%16], 1);
				w[i%16] = x;
			end
			if (i < 20) begin
				f = d ^ (b & (c ^ d)); k = sha1sh_pkg::K0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = sha1sh_pkg::K1;
			end else if (i < 60) begin
				f = (b & c) | (d & (b | c)); k = sha1sh_pkg::K2;
			end else begin
				f = b ^ c ^ d; k = sha1sh_pkg::K3;
			end
			t = rotl(a, 5) + f + e + k + x;
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endtask

	task automatic restart();
		chain[0] = sha1sh_pkg::H0; chain[1] = sha1sh_pkg::H1; chain[2] = sha1sh_pkg::H2;
		chain[3] = sha1sh_pkg::H3; chain[4] = sha1sh_pkg::H4;
		fill = 0;
		blocks = 0;
	endtask

	task automatic hash_request(logic [7:0] data, logic has, logic last);
		logic [63:0] bits;
		int unsigned i;
		sha1sh_pkg::res_t r;
		if (has) begin
			buffer[fill] = data;
			fill++;
			if (fill == 64) begin
				compress();
				fill = 0;
				blocks++;
			end
		end
		if (last) begin
			bits = {23'b0, blocks, 9'b0} + 64'(fill * 8);
			i = fill;
			buffer[i] = sha1sh_pkg::PAD_BYTE;
			i++;
			if (i > sha1sh_pkg::LEN_POS) begin
				while (i < 64) begin
					buffer[i] = 8'h00;
					i++;
				end
				compress();
				i = 0;
			end
			while (i < sha1sh_pkg::LEN_POS) begin
				buffer[i] = 8'h00;
				i++;
			end
			for (int j = 0; j < 8; j++)
				buffer[56+j] = bits[63-8*j -: 8];
			compress();
			for (int j = 0; j < 5; j++) begin
				r.digest_word = chain[j];
				r.word_index = 3'(j);
				r.last_word = (j == 4);
				digest_q.push_back(r);
			end
			restart();
		end
	endtask

	initial begin
		errors = 0;
		restart();
	end

	always @(posedge clk) begin
		sha1sh_pkg::res_t want;
		if (arst_n && s_tvalid && s_tready)
			hash_request(s_tdata, s_tuser, s_tlast);
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected digest word %h last %b", m_tdata, m_tlast);
			end else begin
				want = digest_q.pop_front();
				if (m_tdata[31:0] !== want.digest_word || m_tdata[34:32] !== want.word_index
						|| m_tdata[39:35] !== 5'b0 || m_tlast !== want.last_word) begin
					errors++;
					if (errors <= 10)
						$display("digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
							want.digest_word, want.word_index, want.last_word,
							m_tdata[31:0], m_tdata[34:32], m_tlast);
				end
			end
		end
		pending = digest_q.size();
	end
endmodule

// ----- sim/sha1_stream_hasher_core_test.sv -----
module sha1_stream_hasher_core_test;
	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [7:0] s_tdata = 0;
	logic s_tuser = 0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [39:0] m_tdata;
	logic m_tlast;
	int errors, pending;
	bit stim_done = 0;

	always #10 clk = ~clk;

	sha1_stream_hasher_core dut (.*);
	sha1_stream_hasher_checker chk (.*);

	function automatic int gap_len();
		if ($urandom_range(3) != 0) return 0;
		return ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(3, 1);
	endfunction

	// called at a falling edge; leaves tvalid high, the caller drops it when idle
	task automatic send(logic [7:0] data, logic has, logic last);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(negedge clk);
		end
		s_tdata <= data; s_tuser <= has; s_tlast <= last; s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_message(int len, bit empty_tail);
		for (int i = 0; i < len; i++)
			send(8'($urandom_range(255)), 1'b1, !empty_tail && i == len - 1);
		if (empty_tail || len == 0) send(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	always @(negedge clk) begin
		if ($urandom_range(5) == 0 && $urandom_range(9) == 0)
			m_tready <= 0;
		else if ($urandom_range(3) == 0)
			m_tready <= ~m_tready;
		else
			m_tready <= 1;
	end

	initial begin
		int n, len;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send(8'h00, 1'b0, 1'b1);
		send(8'hff, 1'b0, 1'b0);
		send(8'h61, 1'b1, 1'b0); send(8'h62, 1'b1, 1'b0); send(8'h63, 1'b1, 1'b1);
		send(8'hff, 1'b1, 1'b1);
		send(8'h00, 1'b1, 1'b1);
		send_message(56, 0);
		send_message(64, 0);
		s_tvalid <= 0;
		wait (pending == 0);
		repeat (200) @(negedge clk);
		n = 0;
		while (n < 130) begin
			case ($urandom_range(5))
				0: len = $urandom_range(3);
				1: len = $urandom_range(66, 54);
				2: len = $urandom_range(130, 120);
				default: len = $urandom_range(20);
			endcase
			if ($urandom_range(7) == 0) send(8'($urandom_range(255)), 1'b0, 1'b0);
			send_message(len, $urandom_range(3) == 0);
			n += len + 1;
		end
		s_tvalid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		wait (pending == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("sha1_stream_hasher_core_test passed");
		else
			$display("sha1_stream_hasher_core_test failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("sha1_stream_hasher_core_test failed");
		$finish;
	end
endmodule
